// ----- sv/rcc_pkg.sv -----
// types, constants and helper functions for the rgb 3x3 convolution block
package rcc_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int KERNEL_DIM  = 3;
    localparam int KERNEL_TAPS = KERNEL_DIM * KERNEL_DIM;
    localparam int NUM_CH      = 3;

    localparam int PIX_W  = 8;
    localparam int RGB_W  = NUM_CH * PIX_W;
    localparam int LS_W   = 2 * RGB_W;
    localparam int DIM_W  = 12;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int OROW_W = $clog2(MAX_HEIGHT);

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int KLO_W      = 64;
    localparam int KHI_W      = 8;

    localparam int PROD_W = 16;
    localparam int RSUM_W = 18;
    localparam int SUM_W  = 20;
    localparam int PIX_MAX = 255;

    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int PEND_W   = $clog2(OQ_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LOW   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HIGH  = 4'd3;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;
    localparam logic [KLO_W-1:0] KLO_RST    = 64'h0000_0001_0000_0000;
    localparam logic [KHI_W-1:0] KHI_RST    = 8'h00;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             frame_end;
    } t_pix_out;

    typedef struct packed {
        logic row_top;
        logic row_bot;
        logic col_lft;
        logic col_rgt;
    } t_mask;

    typedef struct packed {
        logic             valid;
        logic             write;
        logic [COL_W-1:0] addr;
        logic [RGB_W-1:0] pix;
        logic             emit;
        t_mask            mask;
        logic             last;
    } t_op;

    function automatic logic [DIM_W-1:0] f_clamp_dim(input logic [DIM_W-1:0] v,
                                                     input int maxv);
        logic [DIM_W-1:0] d;
        d = v;
        if (d == '0) d = DIM_W'(1);
        if (int'(d) > maxv) d = DIM_W'(maxv);
        return d;
    endfunction

    function automatic logic f_trigger(input logic [COL_W-1:0] col,
                                       input logic [IROW_W-1:0] row);
        return (row >= IROW_W'(2)) || ((row == IROW_W'(1)) && (col != '0));
    endfunction

    function automatic logic signed [PIX_W-1:0] f_coeff(input logic [KLO_W-1:0] lo,
                                                        input logic [KHI_W-1:0] hi,
                                                        input int idx);
        logic [PIX_W-1:0] b;
        if (idx < 8) b = lo[PIX_W*idx +: PIX_W];
        else b = hi;
        return $signed(b);
    endfunction

endpackage

// ----- sv/rgb_conv3x3_clamp.sv -----
// rgb 3x3 zero-padded convolution with clamping, line stores in one synchronous memory
//
// Pixels enter in raster order, one transaction per clock; each pixel transaction
// returns the output pixel whose 3x3 neighbourhood it completes, and once all pixels
// of the image are in, each flush transaction returns one of the remaining outputs
// (width+1, or width for a one-row image) with the bottom border treated as absent.
// The last output of an image carries frame_end and rearms the block for the next
// image. The two line stores live side by side in one 2048 x 48 memory with a
// registered read; each column shift reads the entry of its column and writes it
// back in the next cycle, with a bypass when the next shift hits the same column
// (one-pixel-wide images). The sustained rate is one transaction per clock while
// results are taken. The one exception is the first flush of a one-row image, which
// shifts two columns through the single read port, holding off the next transaction
// meanwhile. Transactions pass memory read, window shift, products, row sums, final
// sum and clamp. Results pass through an 8-entry output queue and the input side is
// throttled by a count of results in flight, so input keeps flowing while a result
// waits to be taken. Writes to image_width or image_height restart the frame; the
// line stores need no clearing pass since unwritten entries only reach masked taps.
module rgb_conv3x3_clamp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rcc_pkg::t_pix_in               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rcc_pkg::t_pix_out              o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rcc_pkg::*;

    // configuration
    logic [DIM_W-1:0] r_width, r_height;
    logic [KLO_W-1:0] r_kern_lo;
    logic [KHI_W-1:0] r_kern_hi;

    // position counters
    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic [IROW_W-1:0] r_in_row, n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [OROW_W-1:0] r_out_row, n_out_row;

    // second column shift of a two-shift flush
    logic r_extra_valid, n_extra_valid;
    t_op  r_extra_op, n_extra_op;

    // results accepted but not yet delivered
    logic [PEND_W-1:0] r_pend, n_pend;

    logic w_cfg_wr, w_dim_wr;
    logic w_acc, w_is_pix, w_pix_room, w_emit;
    logic w_trig0;
    logic [COL_W-1:0]  w_c1, w_c2;
    logic [IROW_W-1:0] w_r1, w_r2;
    logic w_out_wrap, w_last;
    t_mask w_mask;
    t_op  w_issue;

    // line store memory: {upper row, middle row} per column
    logic [LS_W-1:0] r_ls [MAX_WIDTH];
    logic [LS_W-1:0] r_ls_rd;
    logic            r_fwd_hit;
    logic [LS_W-1:0] r_fwd_data;
    logic [LS_W-1:0] w_ls_data, w_ls_wdata;
    logic            w_ls_we;
    logic [RGB_W-1:0] w_up, w_mid;

    // pipeline stages
    t_op              r_s1;
    logic [RGB_W-1:0] r_win [KERNEL_TAPS];
    logic             r_s2_vld, r_s2_last;
    t_mask            r_s2_mask;
    logic             r_s3_vld, r_s3_last;
    logic signed [PROD_W-1:0] r_prod [NUM_CH][KERNEL_TAPS];
    logic signed [PROD_W-1:0] w_prod [NUM_CH][KERNEL_TAPS];
    logic             r_s4_vld, r_s4_last;
    logic signed [RSUM_W-1:0] r_rsum [NUM_CH][KERNEL_DIM];
    logic signed [RSUM_W-1:0] w_rsum [NUM_CH][KERNEL_DIM];
    logic [PIX_W-1:0] w_clamped [NUM_CH];

    // output queue
    t_pix_out          r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_oq_wp, r_oq_rp;
    logic [PEND_W-1:0] r_oq_cnt;
    logic              w_push, w_pop;
    t_pix_out          w_res;

    // ---------------------------------------------------------------- handshakes
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_dim_wr    = w_cfg_wr &&
                         ((i_cfg_index == CFG_IMAGE_WIDTH) || (i_cfg_index == CFG_IMAGE_HEIGHT));
    // credit check: every accepted result has a queue entry waiting for it
    assign o_in_ready  = !r_extra_valid && (r_pend < PEND_W'(OQ_DEPTH));
    assign w_acc       = i_in_valid && o_in_ready;
    assign o_out_valid = (r_oq_cnt != '0);
    assign o_out_data  = r_oq[r_oq_rp];
    assign w_pop       = o_out_valid && i_out_ready;

    // ---------------------------------------------------------------- config regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
            r_kern_lo <= KLO_RST;
            r_kern_hi <= KHI_RST;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width   <= f_clamp_dim(i_cfg_data[DIM_W-1:0], MAX_WIDTH);
                CFG_IMAGE_HEIGHT: r_height  <= f_clamp_dim(i_cfg_data[DIM_W-1:0], MAX_HEIGHT);
                CFG_KERNEL_LOW:   r_kern_lo <= i_cfg_data[KLO_W-1:0];
                CFG_KERNEL_HIGH:  r_kern_hi <= i_cfg_data[KHI_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- stage 0: decode
    // position after one and after two column shifts
    always_comb begin
        if ((DIM_W'(r_in_col) + DIM_W'(1)) >= r_width) begin
            w_c1 = '0;
            w_r1 = r_in_row + IROW_W'(1);
        end else begin
            w_c1 = r_in_col + COL_W'(1);
            w_r1 = r_in_row;
        end
        if ((DIM_W'(w_c1) + DIM_W'(1)) >= r_width) begin
            w_c2 = '0;
            w_r2 = w_r1 + IROW_W'(1);
        end else begin
            w_c2 = w_c1 + COL_W'(1);
            w_r2 = w_r1;
        end
    end

    assign w_trig0    = f_trigger(r_in_col, r_in_row);
    assign w_is_pix   = (i_in_data.op == OP_PIXEL);
    assign w_pix_room = (DIM_W'(r_in_row) < r_height);

    // border masks of the next output pixel
    assign w_out_wrap     = (DIM_W'(r_out_col) + DIM_W'(1)) >= r_width;
    assign w_mask.row_top = (r_out_row == '0);
    assign w_mask.row_bot = (DIM_W'(r_out_row) + DIM_W'(1)) >= r_height;
    assign w_mask.col_lft = (r_out_col == '0);
    assign w_mask.col_rgt = w_out_wrap;
    assign w_last         = w_mask.row_bot && w_mask.col_rgt;

    always_comb begin
        w_issue       = '0;
        w_emit        = 1'b0;
        n_extra_valid = 1'b0;
        n_extra_op    = r_extra_op;
        n_in_col      = r_in_col;
        n_in_row      = r_in_row;
        n_out_col     = r_out_col;
        n_out_row     = r_out_row;

        if (r_extra_valid) begin
            w_issue = r_extra_op;
        end else if (w_acc) begin
            if (w_is_pix) begin
                // pixel once the image is complete is dropped
                if (w_pix_room) begin
                    w_issue.valid = 1'b1;
                    w_issue.write = 1'b1;
                    w_issue.addr  = r_in_col;
                    w_issue.pix   = {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
                    w_issue.emit  = w_trig0;
                    w_issue.mask  = w_mask;
                    w_issue.last  = w_last;
                    w_emit        = w_trig0;
                    n_in_col      = w_c1;
                    n_in_row      = w_r1;
                end
            end else if (!w_pix_room) begin
                // flush: shift zero bottom rows until a window completes
                w_issue.valid = 1'b1;
                w_issue.write = 1'b0;
                w_issue.addr  = r_in_col;
                w_issue.pix   = '0;
                w_issue.mask  = w_mask;
                w_issue.last  = w_last;
                w_emit        = 1'b1;
                if (w_trig0) begin
                    w_issue.emit = 1'b1;
                    n_in_col     = w_c1;
                    n_in_row     = w_r1;
                end else begin
                    w_issue.emit     = 1'b0;
                    n_extra_valid    = 1'b1;
                    n_extra_op.valid = 1'b1;
                    n_extra_op.write = 1'b0;
                    n_extra_op.addr  = w_c1;
                    n_extra_op.pix   = '0;
                    n_extra_op.emit  = 1'b1;
                    n_extra_op.mask  = w_mask;
                    n_extra_op.last  = w_last;
                    n_in_col         = w_c2;
                    n_in_row         = w_r2;
                end
            end
        end

        if (w_emit) begin
            if (w_last) begin
                // frame end rearms all counters
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (w_out_wrap) begin
                n_out_col = '0;
                n_out_row = r_out_row + OROW_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end

        if (w_dim_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    assign n_pend = r_pend + PEND_W'(w_emit) - PEND_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col      <= '0;
            r_in_row      <= '0;
            r_out_col     <= '0;
            r_out_row     <= '0;
            r_extra_valid <= 1'b0;
            r_extra_op    <= '0;
            r_pend        <= '0;
        end else begin
            r_in_col      <= n_in_col;
            r_in_row      <= n_in_row;
            r_out_col     <= n_out_col;
            r_out_row     <= n_out_row;
            r_extra_valid <= n_extra_valid;
            r_extra_op    <= n_extra_op;
            r_pend        <= n_pend;
        end
    end

    // ---------------------------------------------------------------- line store memory
    assign w_ls_data  = r_fwd_hit ? r_fwd_data : r_ls_rd;
    assign w_up       = w_ls_data[LS_W-1:RGB_W];
    assign w_mid      = w_ls_data[RGB_W-1:0];
    assign w_ls_we    = r_s1.valid && r_s1.write;
    // middle row moves up, new pixel becomes the middle row
    assign w_ls_wdata = {w_mid, r_s1.pix};

    always_ff @(posedge i_clk) begin
        if (w_ls_we) r_ls[r_s1.addr] <= w_ls_wdata;
        r_ls_rd <= r_ls[w_issue.addr];
    end

    // bypass for a read of the column being written back in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= w_ls_we && (r_s1.addr == w_issue.addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= w_ls_wdata;
    end

    // ---------------------------------------------------------------- stage 1: window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KERNEL_TAPS; i++) r_win[i] <= '0;
        end else if (r_s1.valid) begin
            for (int r = 0; r < KERNEL_DIM; r++) begin
                for (int c = 0; c < KERNEL_DIM - 1; c++) begin
                    r_win[r*KERNEL_DIM + c] <= r_win[r*KERNEL_DIM + c + 1];
                end
            end
            r_win[KERNEL_DIM-1]   <= w_up;
            r_win[2*KERNEL_DIM-1] <= w_mid;
            r_win[3*KERNEL_DIM-1] <= r_s1.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1.valid && r_s1.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_mask <= r_s1.mask;
        r_s2_last <= r_s1.last;
    end

    // ---------------------------------------------------------------- stage 2: products
    always_comb begin
        logic signed [PROD_W:0] v_k, v_p, v_m;
        logic signed [PIX_W-1:0] v_coef;
        logic [PIX_W-1:0] v_px;
        logic v_off;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int r = 0; r < KERNEL_DIM; r++) begin
                for (int c = 0; c < KERNEL_DIM; c++) begin
                    v_coef = f_coeff(r_kern_lo, r_kern_hi, r*KERNEL_DIM + c);
                    v_px   = r_win[r*KERNEL_DIM + c][RGB_W-1-ch*PIX_W -: PIX_W];
                    v_off  = (r == 0 && r_s2_mask.row_top) ||
                             (r == KERNEL_DIM-1 && r_s2_mask.row_bot) ||
                             (c == 0 && r_s2_mask.col_lft) ||
                             (c == KERNEL_DIM-1 && r_s2_mask.col_rgt);
                    v_k = {{(PROD_W+1-PIX_W){v_coef[PIX_W-1]}}, v_coef};
                    v_p = {{(PROD_W+1-PIX_W){1'b0}}, v_px};
                    v_m = v_k * v_p;
                    w_prod[ch][r*KERNEL_DIM + c] = v_off ? '0 : v_m[PROD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_last <= r_s2_last;
        r_prod    <= w_prod;
    end

    // ---------------------------------------------------------------- stage 3: row sums
    always_comb begin
        logic signed [RSUM_W-1:0] v_acc;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int r = 0; r < KERNEL_DIM; r++) begin
                v_acc = '0;
                for (int c = 0; c < KERNEL_DIM; c++) begin
                    v_acc = v_acc + {{(RSUM_W-PROD_W){r_prod[ch][r*KERNEL_DIM+c][PROD_W-1]}},
                                     r_prod[ch][r*KERNEL_DIM+c]};
                end
                w_rsum[ch][r] = v_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_last <= r_s3_last;
        r_rsum    <= w_rsum;
    end

    // ---------------------------------------------------------------- stage 4: sum and clamp
    always_comb begin
        logic signed [SUM_W-1:0] v_tot;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            v_tot = '0;
            for (int r = 0; r < KERNEL_DIM; r++) begin
                v_tot = v_tot + {{(SUM_W-RSUM_W){r_rsum[ch][r][RSUM_W-1]}}, r_rsum[ch][r]};
            end
            if (v_tot < 0) w_clamped[ch] = '0;
            else if (v_tot > SUM_W'(PIX_MAX)) w_clamped[ch] = PIX_W'(PIX_MAX);
            else w_clamped[ch] = v_tot[PIX_W-1:0];
        end
        w_res.red_out   = w_clamped[0];
        w_res.green_out = w_clamped[1];
        w_res.blue_out  = w_clamped[2];
        w_res.frame_end = r_s4_last;
    end

    assign w_push = r_s4_vld;

    // ---------------------------------------------------------------- output queue
    always_ff @(posedge i_clk) begin
        if (w_push) r_oq[r_oq_wp] <= w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (w_push) r_oq_wp <= r_oq_wp + OQ_PTR_W'(1);
            if (w_pop) r_oq_rp <= r_oq_rp + OQ_PTR_W'(1);
            r_oq_cnt <= r_oq_cnt + PEND_W'(w_push) - PEND_W'(w_pop);
        end
    end

    // ---------------------------------------------------------------- assertions
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(OQ_DEPTH))
        else $error("results in flight exceed output queue depth");

    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_oq_cnt < PEND_W'(OQ_DEPTH)))
        else $error("output queue written while full");

    a_oq_within_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= r_pend)
        else $error("queued results not covered by pending count");

    a_extra_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_extra_valid |-> $past(i_in_valid && o_in_ready && (i_in_data.op == OP_FLUSH)))
        else $error("second column shift without a flush transaction");

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for the rgb 3x3 zero-padded convolution with clamping
module tb;
    import rcc_pkg::*;

    localparam int SETTLE_CYCLES  = 12;    // pipeline depth plus margin after the last result
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction before giving up
    localparam int RANDOM_ITEMS   = 600;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = '1;  // no register behind this one

    typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_TRICKLE} t_rx_pattern;
    typedef enum int {KS_ANY, KS_SIGNED_SMALL, KS_SMOOTH} t_kernel_style;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_pix_in               i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_pix_out              o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    rgb_conv3x3_clamp dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // prediction of the convolution, updated on every accepted transaction
    // ---------------------------------------------------------------
    logic [RGB_W-1:0] row_above [MAX_WIDTH];   // row y-2 per column
    logic [RGB_W-1:0] row_prev  [MAX_WIDTH];   // row y-1 per column
    logic [RGB_W-1:0] nbhd      [KERNEL_TAPS]; // 3x3 window, shifts left one column per push
    int               col_in, row_in, col_out, row_out;
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [KLO_W-1:0] klo_reg;
    logic [KHI_W-1:0] khi_reg;

    t_pix_out expected_pixels [$];
    bit       frame_closed;   // last predicted output carried frame_end
    int       frame_items;
    int       mismatches   = 0;
    int       stall_cycles = 0;

    // idling knobs
    bit          tx_idle_en  = 1'b0;
    bit          rx_stall_en = 1'b0;
    int          tx_burst_left = 0;
    int          rx_span = 0;
    int          rx_tick = 0;
    t_rx_pattern rx_mode = RX_OPEN;
    t_pix_out    want;

    function automatic void clear_position();
        col_in  = 0;
        row_in  = 0;
        col_out = 0;
        row_out = 0;
    endfunction

    function automatic void model_reset();
        for (int x = 0; x < MAX_WIDTH; x++) begin
            row_above[x] = '0;
            row_prev[x]  = '0;
        end
        for (int t = 0; t < KERNEL_TAPS; t++) nbhd[t] = '0;
        clear_position();
        width_reg  = WIDTH_RST;
        height_reg = HEIGHT_RST;
        klo_reg    = KLO_RST;
        khi_reg    = KHI_RST;
    endfunction

    function automatic void model_config(input logic [CFG_IDX_W-1:0]  index,
                                         input logic [CFG_DATA_W-1:0] value);
        case (index)
            CFG_IMAGE_WIDTH: begin
                width_reg = value[DIM_W-1:0];
                clear_position();
            end
            CFG_IMAGE_HEIGHT: begin
                height_reg = value[DIM_W-1:0];
                clear_position();
            end
            CFG_KERNEL_LOW:  klo_reg = value;
            CFG_KERNEL_HIGH: khi_reg = value[KHI_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int active_dim(input logic [DIM_W-1:0] v, input int maxv);
        int d;
        d = int'(v);
        if (d < 1) d = 1;
        if (d > maxv) d = maxv;
        return d;
    endfunction

    function automatic int tap_coeff(input int idx);
        logic [PIX_W-1:0] b;
        if (idx < 8) b = klo_reg[PIX_W*idx +: PIX_W];
        else b = khi_reg;
        return b[PIX_W-1] ? int'(b) - 256 : int'(b);
    endfunction

    function automatic logic [PIX_W-1:0] clamp_level(input int s);
        if (s < 0) return '0;
        if (s > PIX_MAX) return PIX_W'(PIX_MAX);
        return PIX_W'(s);
    endfunction

    // the window of the next output is complete once the input is past row 1, column 0
    function automatic bit starts_output();
        return (row_in >= 2) || (row_in == 1 && col_in >= 1);
    endfunction

    function automatic void shift_column(input logic [RGB_W-1:0] bottom, input bit store,
                                         input int w);
        int               x;
        logic [RGB_W-1:0] up, mid;
        x   = (col_in >= MAX_WIDTH) ? 0 : col_in;
        up  = row_above[x];
        mid = row_prev[x];
        if (store) begin
            row_above[x] = mid;
            row_prev[x]  = bottom;
        end
        for (int r = 0; r < KERNEL_DIM; r++) begin
            nbhd[r*KERNEL_DIM]     = nbhd[r*KERNEL_DIM + 1];
            nbhd[r*KERNEL_DIM + 1] = nbhd[r*KERNEL_DIM + 2];
        end
        nbhd[2] = up;
        nbhd[5] = mid;
        nbhd[8] = bottom;
        col_in++;
        if (col_in >= w) begin
            col_in = 0;
            row_in++;
        end
    endfunction

    function automatic t_pix_out conv_emit(input int w, input int h);
        int               acc [NUM_CH];
        int               k;
        bit               masked;
        logic [RGB_W-1:0] px;
        t_pix_out         res;
        acc = '{default: 0};
        for (int r = 0; r < KERNEL_DIM; r++) begin
            for (int c = 0; c < KERNEL_DIM; c++) begin
                // taps beyond the image border count as zero
                masked = (r == 0 && row_out == 0) || (r == 2 && row_out + 1 >= h) ||
                         (c == 0 && col_out == 0) || (c == 2 && col_out + 1 >= w);
                if (!masked) begin
                    px = nbhd[r*KERNEL_DIM + c];
                    k  = tap_coeff(r*KERNEL_DIM + c);
                    acc[0] += k * int'(px[23:16]);
                    acc[1] += k * int'(px[15:8]);
                    acc[2] += k * int'(px[7:0]);
                end
            end
        end
        res.red_out   = clamp_level(acc[0]);
        res.green_out = clamp_level(acc[1]);
        res.blue_out  = clamp_level(acc[2]);
        res.frame_end = (row_out + 1 >= h) && (col_out + 1 >= w);
        if (res.frame_end) begin
            clear_position();
        end else begin
            col_out++;
            if (col_out >= w) begin
                col_out = 0;
                row_out++;
            end
        end
        return res;
    endfunction

    // returns 1 when the transaction yields an output pixel
    function automatic bit convolve_item(input t_pix_in item, output t_pix_out res);
        int w, h;
        bit trig;
        w   = active_dim(width_reg, MAX_WIDTH);
        h   = active_dim(height_reg, MAX_HEIGHT);
        res = '0;
        if (item.op == OP_PIXEL) begin
            if (row_in >= h) return 1'b0;   // image already complete
            trig = starts_output();
            shift_column({item.red_in, item.green_in, item.blue_in}, 1'b1, w);
            if (!trig) return 1'b0;
            res = conv_emit(w, h);
            return 1'b1;
        end
        if (row_in < h) return 1'b0;        // flush before the last pixel
        // one-row images push two empty columns on the first flush
        trig = 1'b0;
        for (int i = 0; i < 2 && !trig; i++) begin
            trig = starts_output();
            shift_column('0, 1'b0, w);
        end
        res = conv_emit(w, h);
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [PIX_W-1:0] rand_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pix_in pixel_of(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                         input logic [PIX_W-1:0] b);
        t_pix_in item;
        item.op       = OP_PIXEL;
        item.red_in   = r;
        item.green_in = g;
        item.blue_in  = b;
        return item;
    endfunction

    function automatic t_pix_in rand_pixel();
        return pixel_of(rand_level(), rand_level(), rand_level());
    endfunction

    // flush payload is don't-care, so it carries noise
    function automatic t_pix_in flush_of();
        t_pix_in item;
        item    = t_pix_in'($urandom);
        item.op = OP_FLUSH;
        return item;
    endfunction

    function automatic void pick_kernel(input t_kernel_style style,
                                        output logic [KLO_W-1:0] klo,
                                        output logic [KHI_W-1:0] khi);
        logic [PIX_W-1:0] b;
        klo = '0;
        khi = '0;
        for (int t = 0; t < KERNEL_TAPS; t++) begin
            case (style)
                KS_ANY:          b = PIX_W'($urandom);
                KS_SIGNED_SMALL: b = PIX_W'($urandom_range(0, 6) - 3);
                default:         b = PIX_W'($urandom_range(0, 2));
            endcase
            if (t < 8) klo[PIX_W*t +: PIX_W] = b;
            else khi = b;
        end
    endfunction

    // returns at the falling edge before the accepting clock edge
    task automatic send_item(input t_pix_in item);
        t_pix_out res;
        @(posedge i_clk);
        if (tx_idle_en && tx_burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            tx_burst_left = $urandom_range(1, 30);
        end
        if (tx_burst_left > 0) tx_burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        if (convolve_item(item, res)) begin
            expected_pixels.push_back(res);
            frame_closed = res.frame_end;
        end
    endtask

    // wait until every predicted pixel is out and the pipeline is quiet
    task automatic drain_pipeline();
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        model_config(index, value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // dimension writes carry junk above bit 11, which the block drops
    task automatic load_image_setup(input int w, input int h, input logic [KLO_W-1:0] klo,
                                    input logic [KHI_W-1:0] khi);
        drain_pipeline();
        write_reg(CFG_IMAGE_WIDTH, {20'($urandom), 32'($urandom), DIM_W'(w)});
        write_reg(CFG_IMAGE_HEIGHT, {20'($urandom), 32'($urandom), DIM_W'(h)});
        write_reg(CFG_KERNEL_LOW, klo);
        write_reg(CFG_KERNEL_HIGH, {56'($urandom), khi});
    endtask

    // one whole image; noisy adds ignored flushes and trailing pixels
    task automatic send_frame(input bit noisy);
        int total;
        total = active_dim(width_reg, MAX_WIDTH) * active_dim(height_reg, MAX_HEIGHT);
        frame_closed = 1'b0;
        for (int k = 0; k < total; k++) begin
            if (noisy && $urandom_range(0, 24) == 0) send_item(flush_of());
            send_item(rand_pixel());
            frame_items++;
        end
        if (noisy && $urandom_range(0, 3) == 0) send_item(rand_pixel());
        while (!frame_closed) begin
            send_item(flush_of());
            frame_items++;
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // identity kernel from reset, pixel extremes, early flush, pixel past the image
    task automatic test_reset_kernel();
        drain_pipeline();
        write_reg(CFG_IMAGE_WIDTH, 64'd3);
        write_reg(CFG_IMAGE_HEIGHT, 64'd2);
        tx_idle_en   = 1'b0;
        rx_stall_en  = 1'b0;
        frame_closed = 1'b0;
        send_item(pixel_of(8'h00, 8'h00, 8'h00));
        send_item(pixel_of(8'hFF, 8'hFF, 8'hFF));
        send_item(flush_of());
        send_item(pixel_of(8'hFF, 8'h00, 8'h00));
        send_item(pixel_of(8'h00, 8'hFF, 8'h00));
        send_item(pixel_of(8'h00, 8'h00, 8'hFF));
        send_item(pixel_of(8'h80, 8'h7F, 8'h01));
        send_item(pixel_of(8'h55, 8'hAA, 8'h0F));
        while (!frame_closed) send_item(flush_of());
    endtask

    // saturating kernels, a mixed-sign kernel, and writes to missing registers
    task automatic test_kernel_extremes();
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        load_image_setup(2, 2, {8{8'h7F}}, 8'h7F);
        send_frame(1'b0);
        load_image_setup(2, 2, {8{8'h80}}, 8'h80);
        send_frame(1'b0);
        load_image_setup(2, 2, 64'h01FE_7F80_FF00_0102, 8'hFF);
        write_reg(CFG_LAST_INDEX, '1);
        write_reg(CFG_IMAGE_HEIGHT + CFG_KERNEL_HIGH, '0);
        send_frame(1'b0);
    endtask

    // zero dimensions, one-row and one-column images, and a 2x3 image
    task automatic test_edge_sizes();
        logic [KLO_W-1:0] klo;
        logic [KHI_W-1:0] khi;
        pick_kernel(KS_SIGNED_SMALL, klo, khi);
        load_image_setup(0, 0, klo, khi);
        send_frame(1'b0);
        send_frame(1'b0);
        load_image_setup(5, 1, klo, khi);
        send_frame(1'b1);
        load_image_setup(1, 4, klo, khi);
        send_frame(1'b1);
        load_image_setup(2, 3, klo, khi);
        send_frame(1'b0);
    endtask

    // dimension writes in the middle of an image start over
    task automatic test_restart();
        logic [KLO_W-1:0] klo;
        logic [KHI_W-1:0] khi;
        pick_kernel(KS_SMOOTH, klo, khi);
        load_image_setup(4, 3, klo, khi);
        repeat (7) send_item(rand_pixel());
        drain_pipeline();
        write_reg(CFG_IMAGE_WIDTH, 64'd4);
        send_frame(1'b0);
        repeat (3) send_item(rand_pixel());
        drain_pipeline();
        write_reg(CFG_IMAGE_WIDTH, 64'd6);
        send_frame(1'b0);
    endtask

    // wide and tall images, and out-of-range sizes that clamp to the maximum
    task automatic test_full_size();
        logic [KLO_W-1:0] klo;
        logic [KHI_W-1:0] khi;
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b1;
        pick_kernel(KS_SIGNED_SMALL, klo, khi);
        load_image_setup(120, 2, klo, khi);
        send_frame(1'b0);
        // clamped maximum width: no window completes within the first pixels
        load_image_setup(4095, 4095, klo, khi);
        repeat (40) send_item(rand_pixel());
        send_item(flush_of());
        load_image_setup(1, 30, klo, khi);
        send_frame(1'b0);
    endtask

    task automatic test_random_frames();
        logic [KLO_W-1:0] klo;
        logic [KHI_W-1:0] khi;
        int               w, h, partial;
        frame_items = 0;
        while (frame_items < RANDOM_ITEMS) begin
            pick_kernel(t_kernel_style'($urandom_range(0, 2)), klo, khi);
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
            h = $urandom_range(0, 8);
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            load_image_setup(w, h, klo, khi);
            repeat ($urandom_range(1, 3)) begin
                // sometimes abandon part of an image with a height rewrite
                if ($urandom_range(0, 7) == 0) begin
                    partial = $urandom_range(0, active_dim(width_reg, MAX_WIDTH) *
                                                active_dim(height_reg, MAX_HEIGHT));
                    repeat (partial) send_item(rand_pixel());
                    drain_pipeline();
                    write_reg(CFG_IMAGE_HEIGHT, {52'($urandom), height_reg});
                end
                send_frame(1'b1);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // output side: ready pattern, result checking, watchdog
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_span == 0) begin
            rx_span = $urandom_range(8, 150);
            rx_mode = t_rx_pattern'($urandom_range(0, 3));
        end
        rx_span--;
        rx_tick++;
        if (!rx_stall_en) begin
            i_out_ready <= 1'b1;
        end else begin
            case (rx_mode)
                RX_OPEN:  i_out_ready <= 1'b1;
                RX_COIN:  i_out_ready <= 1'($urandom_range(0, 1));
                RX_COMB:  i_out_ready <= ((rx_tick % 7) < 3);
                default:  i_out_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    function automatic void compare_field(input string name, input logic [PIX_W-1:0] exp_v,
                                          input logic [PIX_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // outputs are stable at the falling edge; a transaction seen here completes next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: output transaction with nothing expected, actual %h",
                         $time, o_out_data);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                compare_field("red_out", want.red_out, o_out_data.red_out);
                compare_field("green_out", want.green_out, o_out_data.green_out);
                compare_field("blue_out", want.blue_out, o_out_data.blue_out);
                compare_field("frame_end", PIX_W'(want.frame_end), PIX_W'(o_out_data.frame_end));
            end
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("%0t: no transaction for %0d cycles, %0d pixels still expected",
                 $time, WATCHDOG_LIMIT, expected_pixels.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        model_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_kernel();
        test_kernel_extremes();
        test_edge_sizes();
        test_restart();
        test_full_size();
        test_random_frames();
        drain_pipeline();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
